@@ src/bkjh_pkg.sv @@
// Shared types, constants and mix shift table for the byte-key hash block.
`default_nettype none
package bkjh_pkg;

   localparam logic [31:0] GoldenWord = 32'h9e3779b9;
   localparam int          BlockLen   = 12;
   localparam int          MixSteps   = 9;
   localparam logic [3:0]  LastByte   = 4'(BlockLen - 1);
   localparam logic [3:0]  LastStep   = 4'(MixSteps - 1);

   // One unit of work for the mixer: a block to fold in, a key end, or both.
   typedef struct packed {
      logic [31:0] a_word;
      logic [31:0] b_word;
      logic [31:0] c_word;
      logic [31:0] key_len;
      logic        has_block;
      logic        is_final;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MIX  = 4'b0010,
      ST_LEN  = 4'b0100,
      ST_DONE = 4'b1000
   } back_state_type;

   function automatic logic [4:0] mix_shift(input logic [3:0] step);
      logic [4:0] sh;
      begin
         case (step)
            4'd0:    sh = 5'd13;
            4'd1:    sh = 5'd8;
            4'd2:    sh = 5'd13;
            4'd3:    sh = 5'd12;
            4'd4:    sh = 5'd16;
            4'd5:    sh = 5'd5;
            4'd6:    sh = 5'd3;
            4'd7:    sh = 5'd10;
            4'd8:    sh = 5'd15;
            default: sh = 5'd0;
         endcase
         return sh;
      end
   endfunction

endpackage
`default_nettype wire

@@ src/bkjh_front.sv @@
// Front end: packs key bytes into 12-byte blocks and issues mixer jobs.
`default_nettype none
module bkjh_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_has_byte,
   input  wire logic             req_last,
   input  wire logic             jobq_full,
   output logic                  job_push,
   output bkjh_pkg::job_type     job
);
   import bkjh_pkg::*;

   logic [7:0]  bytes_ff [BlockLen];
   logic [7:0]  bytes_in [BlockLen];
   logic [7:0]  bytes_nx [BlockLen];
   logic [3:0]  fill_ff, fill_in;
   logic [31:0] len_ff, len_in, len_nx;
   logic        accept, blk, emit;

   assign req_full = jobq_full;
   assign accept   = req_push & ~jobq_full;
   assign blk      = req_has_byte & (fill_ff == LastByte);
   assign emit     = blk | req_last;
   assign job_push = accept & emit;
   assign len_nx   = len_ff + 32'(req_has_byte);

   always_comb begin
      bytes_nx = bytes_ff;
      if (req_has_byte) begin
         bytes_nx[fill_ff] = req_data_byte;
      end
   end

   always_comb begin
      job.a_word    = {bytes_nx[3], bytes_nx[2], bytes_nx[1], bytes_nx[0]};
      job.b_word    = {bytes_nx[7], bytes_nx[6], bytes_nx[5], bytes_nx[4]};
      // tail bytes sit one byte higher in c than block bytes
      job.c_word    = blk ? {bytes_nx[11], bytes_nx[10], bytes_nx[9], bytes_nx[8]}
                          : {bytes_nx[10], bytes_nx[9], bytes_nx[8], 8'h00};
      job.key_len   = len_nx;
      job.has_block = blk;
      job.is_final  = req_last;
   end

   always_comb begin
      bytes_in = bytes_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      if (accept) begin
         if (emit) begin
            for (int i = 0; i < BlockLen; i++) begin
               bytes_in[i] = 8'h00;
            end
            fill_in = 4'd0;
         end else begin
            bytes_in = bytes_nx;
            fill_in  = fill_ff + 4'(req_has_byte);
         end
         len_in = req_last ? 32'd0 : len_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BlockLen; i++) begin
            bytes_ff[i] <= 8'h00;
         end
         fill_ff <= 4'd0;
         len_ff  <= 32'd0;
      end else begin
         bytes_ff <= bytes_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
      end
   end

endmodule
`default_nettype wire

@@ src/bkjh_jobq.sv @@
// Small job queue between the byte packer and the mixer.
`default_nettype none
module bkjh_jobq #(
   parameter int DEPTH = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  bkjh_pkg::job_type  push_job,
   output logic               full,
   input  wire logic          pop,
   output logic               empty,
   output bkjh_pkg::job_type  head
);
   import bkjh_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

   job_type         mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full    = (cnt_ff == CntW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ src/bkjh_back.sv @@
// Back end: folds jobs into a, b, c, runs the mix one step a cycle, queues hashes.
`default_nettype none
module bkjh_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          job_valid,
   input  bkjh_pkg::job_type  job,
   output logic               job_pop,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic [31:0]        rsp_hash_value
);
   import bkjh_pkg::*;

   localparam logic [1:0] RspDepth = 2'd2;

   back_state_type state_ff, state_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [31:0] a_mx, b_mx, c_mx;
   logic [31:0] len_ff, len_in;
   logic [3:0]  step_ff, step_in;
   logic        block_ff, block_in, final_ff, final_in;
   logic [4:0]  sh;
   logic        push_rsp, do_pop;
   logic [31:0] slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0]  cnt_ff, cnt_in;

   // one of the nine subtract/xor-shift steps
   always_comb begin
      a_mx = a_ff;
      b_mx = b_ff;
      c_mx = c_ff;
      sh   = mix_shift(step_ff);
      unique case (step_ff) inside
         4'd0, 4'd3, 4'd6: a_mx = (a_ff - b_ff - c_ff) ^ (c_ff >> sh);
         4'd1, 4'd4, 4'd7: b_mx = (b_ff - c_ff - a_ff) ^ (a_ff << sh);
         default:          c_mx = (c_ff - a_ff - b_ff) ^ (b_ff >> sh);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      len_in   = len_ff;
      step_in  = step_ff;
      block_in = block_ff;
      final_in = final_ff;
      job_pop  = 1'b0;
      push_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               a_in     = a_ff + job.a_word;
               b_in     = b_ff + job.b_word;
               c_in     = c_ff + job.c_word + (job.has_block ? 32'd0 : job.key_len);
               len_in   = job.key_len;
               block_in = job.has_block;
               final_in = job.is_final;
               step_in  = 4'd0;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            a_in = a_mx;
            b_in = b_mx;
            c_in = c_mx;
            if (step_ff == LastStep) begin
               step_in = 4'd0;
               if (final_ff && block_ff) begin
                  state_in = ST_LEN;
               end else if (final_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_LEN: begin
            // key ended on a block boundary: empty tail, length only
            c_in     = c_ff + len_ff;
            block_in = 1'b0;
            state_in = ST_MIX;
         end
         ST_DONE: begin
            if (cnt_ff != RspDepth) begin
               push_rsp = 1'b1;
               a_in     = GoldenWord;
               b_in     = GoldenWord;
               c_in     = 32'd0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // two-entry result queue
   assign rsp_empty      = (cnt_ff == 2'd0);
   assign rsp_hash_value = slot0_ff;
   assign do_pop         = rsp_pop & ~rsp_empty;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (push_rsp && do_pop) begin
         if (cnt_ff == 2'd1) begin
            slot0_in = c_ff;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = c_ff;
         end
      end else if (push_rsp) begin
         if (cnt_ff == 2'd0) begin
            slot0_in = c_ff;
         end else begin
            slot1_in = c_ff;
         end
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      len_ff   <= len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         a_ff     <= GoldenWord;
         b_ff     <= GoldenWord;
         c_ff     <= 32'd0;
         step_ff  <= 4'd0;
         block_ff <= 1'b0;
         final_ff <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
         step_ff  <= step_in;
         block_ff <= block_in;
         final_ff <= final_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_rsp_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RspDepth)
      else $error("result queue overflow");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= LastStep)
      else $error("mix step out of range");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (state_ff == ST_IDLE) && job_valid)
      else $error("job taken outside idle");

   a_words_reset: assert property (@(posedge clock) disable iff (reset)
      push_rsp |=> (a_ff == GoldenWord) && (b_ff == GoldenWord) && (c_ff == 32'd0))
      else $error("state words not restored after hash");

endmodule
`default_nettype wire

@@ src/byte_key_jenkins_hash.sv @@
// Top level: byte-serial lookup2 hash of a variable-length key.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+------------------------
//  request | req_data_byte, req_has_byte, req_last        | req_push / req_full
//  result  | rsp_hash_value                               | rsp_empty / rsp_pop
//
// Takes one request per cycle while the job queue has room. Each completed
// 12-byte block costs the mixer an add and nine mix steps; a key end costs an
// add, nine mix steps and a result push, plus a length add and nine more mix
// steps when the key ends on a block boundary, so short keys are limited by
// the mixer. Reset is synchronous; no clearing pass. A full result queue
// stalls the mixer, which then fills the job queue and raises req_full.
`default_nettype none
module byte_key_jenkins_hash #(
   parameter int JOB_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_last,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [31:0]      rsp_hash_value
);
   import bkjh_pkg::*;

   job_type in_job, head_job;
   logic    job_push, jobq_full, jobq_empty, job_pop;

   bkjh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_has_byte  (req_has_byte),
      .req_last      (req_last),
      .jobq_full     (jobq_full),
      .job_push      (job_push),
      .job           (in_job)
   );

   bkjh_jobq #(
      .DEPTH (JOB_DEPTH)
   ) u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (in_job),
      .full     (jobq_full),
      .pop      (job_pop),
      .empty    (jobq_empty),
      .head     (head_job)
   );

   bkjh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (~jobq_empty),
      .job            (head_job),
      .job_pop        (job_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule
`default_nettype wire

@@ dv/byte_key_jenkins_hash_tb.sv @@
// Testbench for byte_key_jenkins_hash: directed and random keys checked against a lookup2 predictor.
module testbench;

   localparam int CycleLimit  = 400000;
   localparam int RandomCount = 1400;
   localparam int HoldCycles  = 400;
   localparam int SettleWait  = 40;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } key_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_hash_value;

   // predictor state
   logic [31:0] run_a;
   logic [31:0] run_b;
   logic [31:0] run_c;
   logic [7:0]  block_buf [0:bkjh_pkg::BlockLen-1];
   int          block_count;
   logic [31:0] key_bytes_seen;
   logic [31:0] hash_queue [$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  requests_accepted = 0;
   int  keys_predicted = 0;
   int  hashes_checked = 0;
   int  longest_key = 0;
   bit  gaps_on = 1'b1;
   bit  start_hold = 1'b0;

   key_request_type directed_requests [0:19] = '{
      '{8'h00, 1'b0, 1'b1},   // empty key right after reset
      '{8'ha5, 1'b0, 1'b0},   // idle
      '{8'hff, 1'b1, 1'b1},
      '{8'h00, 1'b1, 1'b1},
      '{8'h80, 1'b1, 1'b0},   // twelve bytes, ends on the block boundary
      '{8'h01, 1'b1, 1'b0},
      '{8'h02, 1'b1, 1'b0},
      '{8'h04, 1'b1, 1'b0},
      '{8'h08, 1'b1, 1'b0},
      '{8'h10, 1'b1, 1'b0},
      '{8'h20, 1'b1, 1'b0},
      '{8'h40, 1'b1, 1'b0},
      '{8'hfe, 1'b1, 1'b0},
      '{8'hfd, 1'b1, 1'b0},
      '{8'hfb, 1'b1, 1'b0},
      '{8'hf7, 1'b1, 1'b1},
      '{8'h7f, 1'b1, 1'b0},   // idle inside a key, then a bare end marker
      '{8'hc3, 1'b0, 1'b0},
      '{8'hfe, 1'b1, 1'b0},
      '{8'h00, 1'b0, 1'b1}
   };

   byte_key_jenkins_hash dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_byte  (req_data_byte),
      .req_has_byte   (req_has_byte),
      .req_last       (req_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hash_value (rsp_hash_value)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Timeout after %0d cycles, %0d hashes outstanding", cycle_count,
                  hash_queue.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0d] MISMATCH: %s", cycle_count, what);
   endtask

   task automatic lookup2_mix(inout logic [31:0] a, inout logic [31:0] b,
                              inout logic [31:0] c);
      a = (a - b - c) ^ (c >> 13);
      b = (b - c - a) ^ (a << 8);
      c = (c - a - b) ^ (b >> 13);
      a = (a - b - c) ^ (c >> 12);
      b = (b - c - a) ^ (a << 16);
      c = (c - a - b) ^ (b >> 5);
      a = (a - b - c) ^ (c >> 3);
      b = (b - c - a) ^ (a << 10);
      c = (c - a - b) ^ (b >> 15);
   endtask

   task automatic clear_hash_state();
      run_a = bkjh_pkg::GoldenWord;
      run_b = bkjh_pkg::GoldenWord;
      run_c = 32'h0;
      for (int i = 0; i < bkjh_pkg::BlockLen; i++) block_buf[i] = 8'h00;
      block_count = 0;
      key_bytes_seen = 32'h0;
   endtask

   task automatic predict_key_request(input logic [7:0] data_byte, input logic has_byte,
                                      input logic last);
      int i;
      if (has_byte) begin
         block_buf[block_count] = data_byte;
         block_count++;
         key_bytes_seen = key_bytes_seen + 32'd1;
         if (block_count == bkjh_pkg::BlockLen) begin
            run_a = run_a + {block_buf[3], block_buf[2], block_buf[1], block_buf[0]};
            run_b = run_b + {block_buf[7], block_buf[6], block_buf[5], block_buf[4]};
            run_c = run_c + {block_buf[11], block_buf[10], block_buf[9], block_buf[8]};
            lookup2_mix(run_a, run_b, run_c);
            block_count = 0;
         end
      end
      if (last) begin
         for (i = 0; i < block_count; i++) begin
            if (i < 4)
               run_a = run_a + (32'(block_buf[i]) << (8 * i));
            else if (i < 8)
               run_b = run_b + (32'(block_buf[i]) << (8 * (i - 4)));
            else
               run_c = run_c + (32'(block_buf[i]) << (8 * (i - 7)));
         end
         run_c = run_c + key_bytes_seen;
         lookup2_mix(run_a, run_b, run_c);
         hash_queue.push_back(run_c);
         if (int'(key_bytes_seen) > longest_key) longest_key = int'(key_bytes_seen);
         keys_predicted++;
         clear_hash_state();
      end
   endtask

   task automatic send_request(input logic [7:0] data_byte, input logic has_byte,
                               input logic last);
      while (gaps_on && $urandom_range(99) < 18) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= data_byte;
      req_has_byte <= has_byte;
      req_last <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      requests_accepted++;
      predict_key_request(data_byte, has_byte, last);
   endtask

   // result side: check what was popped, then choose the next pop
   initial begin : result_sink
      int hold_left;
      logic [31:0] expected_hash;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (hash_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected hash %08h", rsp_hash_value));
            end else begin
               expected_hash = hash_queue.pop_front();
               hashes_checked++;
               if (rsp_hash_value !== expected_hash)
                  report_mismatch($sformatf("hash_value %08h, expected %08h",
                                            rsp_hash_value, expected_hash));
            end
         end
         if (start_hold) begin
            start_hold = 1'b0;
            hold_left = HoldCycles;
         end
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !gaps_on || ($urandom_range(99) >= 18);
         end
      end
   end

   initial begin : request_source
      int sent;
      int key_len;
      int pick;
      bit end_marker;
      bit hold_done;
      bit drain_done;
      sent = 0;
      hold_done = 1'b0;
      drain_done = 1'b0;
      clear_hash_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_requests[k])
         send_request(directed_requests[k].data_byte, directed_requests[k].has_byte,
                      directed_requests[k].last);

      while (sent < RandomCount) begin
         gaps_on = !(sent >= 400 && sent < 650);
         if (!hold_done && sent >= 800) begin
            hold_done = 1'b1;
            start_hold = 1'b1;
         end
         if (!drain_done && sent >= 1100) begin
            drain_done = 1'b1;
            req_push <= 1'b0;
            @(posedge clock);
            while (hash_queue.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(99);
         if (pick < 10)      key_len = 0;
         else if (pick < 20) key_len = $urandom_range(11, 13);
         else if (pick < 65) key_len = $urandom_range(1, 10);
         else if (pick < 92) key_len = $urandom_range(14, 36);
         else                key_len = $urandom_range(37, 120);
         end_marker = (key_len == 0) || ($urandom_range(99) < 25);
         for (int j = 0; j < key_len; j++) begin
            if ($urandom_range(99) < 8) send_request(8'($urandom), 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, (j == key_len - 1) && !end_marker);
            sent++;
         end
         if (end_marker) begin
            send_request(8'($urandom), 1'b0, 1'b1);
            sent++;
         end
      end
      req_push <= 1'b0;
      gaps_on = 1'b1;

      while (hash_queue.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);

      $display("Hashed %0d keys from %0d requests (longest key %0d bytes, %0d hashes checked),",
               keys_predicted, requests_accepted, longest_key, hashes_checked);
      $display("with empty keys, block-boundary ends, idle requests and a long result stall.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
